### src/uss_pkg.sv
// ----------------------------------------------------------------------------
// uss_pkg: shared types and constants of the URL stream splitter
// Character classes, status codes, parse phases and scheme name tables.
// ----------------------------------------------------------------------------
package uss_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

    // register index taken from paddr
    localparam logic REG_DEFAULT_PORT = 1'b0;

    typedef enum logic [2:0] {
        CL_SCHEME = 3'd0,
        CL_SEP    = 3'd1,
        CL_HOST   = 3'd2,
        CL_COLON  = 3'd3,
        CL_PORT   = 3'd4,
        CL_PATH   = 3'd5,
        CL_ERR    = 3'd6
    } class_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_SCHEME  = 2'd1,
        ST_NO_SEP      = 2'd2,
        ST_NO_PATH     = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        PH_SCHEME = 6'b000001,
        PH_SEP    = 6'b000010,
        PH_HOST   = 6'b000100,
        PH_PORT   = 6'b001000,
        PH_PATH   = 6'b010000,
        PH_ERR    = 6'b100000
    } phase_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    typedef struct packed {
        class_t      char_class;
        logic [1:0]  scheme_id;
        logic [15:0] port_value;
        logic        port_saturated;
        status_t     status;
        logic        done_res;
    } result_t;

    function automatic logic [2:0] scheme_len(input logic [1:0] id);
        logic [2:0] len;
        case (id)
            2'd0:    len = 3'd4;
            2'd1:    len = 3'd5;
            2'd2:    len = 3'd3;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [1:0] id, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (id)
            2'd0, 2'd1:
            begin
                case (pos)
                    3'd0:    ch = "h";
                    3'd1:    ch = "t";
                    3'd2:    ch = "t";
                    3'd3:    ch = "p";
                    3'd4:    ch = (id == 2'd1) ? 8'h73 : 8'h00;
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (pos)
                    3'd0:    ch = "f";
                    3'd1:    ch = "t";
                    3'd2:    ch = "p";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "f";
                    3'd2:    ch = "t";
                    3'd3:    ch = "p";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

### src/url_stream_splitter.sv
// ----------------------------------------------------------------------------
// url_stream_splitter: per-character URL classifier
// A character passes the input stage, then the result stage. Throughput: one
// character per cycle while out_ready takes each result, limited by the single
// parse-state step. Reset clears the parse state and both pipeline stages;
// default_port returns to 80. The parse state restarts after each end-of-text.
// ----------------------------------------------------------------------------
module url_stream_splitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   char_in,
    input  logic                         end_of_text,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   char_class,
    output logic [1:0]                   scheme_id,
    output logic [15:0]                  port_value,
    output logic                         port_saturated,
    output logic [1:0]                   status,
    output logic                         done_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uss_pkg::PADDR_W-1:0]  paddr,
    input  logic [uss_pkg::PDATA_W-1:0]  pwdata,
    output logic [uss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import uss_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  char_reg;
    logic        eot_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;
    result_t     step_res;
    logic        advance;
    logic        in_fire;
    logic [15:0] default_port;

    uss_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_port (default_port)
    );

    uss_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .char_in      (char_reg),
        .end_of_text  (eot_reg),
        .default_port (default_port),
        .result       (step_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= char_in;
            eot_reg  <= end_of_text;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign char_class     = res_reg.char_class;
    assign scheme_id      = res_reg.scheme_id;
    assign port_value     = res_reg.port_value;
    assign port_saturated = res_reg.port_saturated;
    assign status         = res_reg.status;
    assign done_res       = res_reg.done_res;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while result stage empty");

    a_colon_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_class == CL_COLON) |-> (port_value == 16'd0) && !port_saturated)
        else $error("port not cleared on port colon");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && port_saturated |-> (port_value == PORT_MAX))
        else $error("saturated port not clamped");

endmodule

### src/uss_cfg.sv
// ----------------------------------------------------------------------------
// uss_cfg: configuration register port
// Holds default_port, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module uss_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uss_pkg::PADDR_W-1:0]  paddr,
    input  logic [uss_pkg::PDATA_W-1:0]  pwdata,
    output logic [uss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [15:0]                  default_port
);
    import uss_pkg::*;

    logic [15:0] default_port_reg;
    logic [15:0] default_port_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_DEFAULT_PORT);

    always_comb
    begin
        default_port_next = default_port_reg;
        if (wr_hit)
        begin
            default_port_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_port_reg <= DEFAULT_PORT_RST;
        end
        else
        begin
            default_port_reg <= default_port_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_DEFAULT_PORT)
        begin
            prdata = {{(PDATA_W-16){1'b0}}, default_port_reg};
        end
    end

    assign default_port = default_port_reg;

endmodule

### src/uss_parser.sv
// ----------------------------------------------------------------------------
// uss_parser: URL parse state and per-character step
// Classifies one character per step and advances the parse state.
// ----------------------------------------------------------------------------
module uss_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        char_in,
    input  logic              end_of_text,
    input  logic [15:0]       default_port,
    output uss_pkg::result_t  result
);
    import uss_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [3:0]  cand_reg,   cand_next;
    logic [15:0] acc_reg,    acc_next;
    logic        colon_reg,  colon_next;
    logic        ended_reg,  ended_next;
    logic        sat_reg,    sat_next;
    status_t     err_reg,    err_next;

    logic [7:0]  lc;
    logic [3:0]  full_cur;
    logic [3:0]  full_new;
    logic [3:0]  ext;
    logic [19:0] acc_x10;
    logic [2:0]  pos_inc;
    class_t      cls;
    logic [1:0]  sid;

    always_comb
    begin
        lc = char_in;
        if (char_in inside {[8'h41:8'h5A]})
        begin
            lc = char_in + 8'h20;
        end
        for (int i = 0; i < 4; i++)
        begin
            full_cur[i] = cand_reg[i] && (scheme_len(2'(i)) == pos_reg);
            ext[i] = cand_reg[i] && (pos_reg < scheme_len(2'(i)))
                     && (lc == scheme_char(2'(i), pos_reg));
        end
    end

    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + {16'b0, char_in[3:0]};
    assign pos_inc = pos_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        acc_next   = acc_reg;
        colon_next = colon_reg;
        ended_next = ended_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        cls        = CL_ERR;

        case (phase_reg)
            PH_SCHEME:
            begin
                if (char_in == CH_COLON && full_cur != 4'b0)
                begin
                    cand_next  = full_cur;
                    phase_next = PH_SEP;
                    pos_next   = 3'd1;
                    cls        = CL_SEP;
                end
                else if (ext != 4'b0)
                begin
                    cand_next = ext;
                    pos_next  = pos_inc;
                    cls       = CL_SCHEME;
                end
                else
                begin
                    err_next   = (full_cur != 4'b0) ? ST_NO_SEP : ST_BAD_SCHEME;
                    cand_next  = 4'b0;
                    phase_next = PH_ERR;
                end
            end
            PH_SEP:
            begin
                if (char_in == CH_SLASH)
                begin
                    cls      = CL_SEP;
                    pos_next = pos_inc;
                    if (pos_inc >= 3'd3)
                    begin
                        phase_next = PH_HOST;
                        pos_next   = 3'd0;
                    end
                end
                else
                begin
                    err_next   = ST_NO_SEP;
                    phase_next = PH_ERR;
                end
            end
            PH_HOST:
            begin
                if (char_in == CH_COLON)
                begin
                    cls        = CL_COLON;
                    colon_next = 1'b1;
                    acc_next   = 16'd0;
                    phase_next = PH_PORT;
                end
                else if (char_in == CH_SLASH)
                begin
                    cls        = CL_PATH;
                    phase_next = PH_PATH;
                end
                else
                begin
                    cls = CL_HOST;
                end
            end
            PH_PORT:
            begin
                if (char_in == CH_SLASH)
                begin
                    cls        = CL_PATH;
                    phase_next = PH_PATH;
                end
                else
                begin
                    cls = CL_PORT;
                    if (!ended_reg)
                    begin
                        if (char_in inside {[8'h30:8'h39]})
                        begin
                            if (sat_reg || acc_x10[19:16] != 4'b0)
                            begin
                                acc_next = PORT_MAX;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_x10[15:0];
                            end
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
            end
            PH_PATH:
            begin
                cls = CL_PATH;
            end
            default:
            begin
                cls = CL_ERR;
            end
        endcase

        for (int i = 0; i < 4; i++)
        begin
            full_new[i] = cand_next[i] && (scheme_len(2'(i)) == pos_next);
        end

        if (end_of_text)
        begin
            case (phase_next)
                PH_SCHEME: err_next = (full_new != 4'b0) ? ST_NO_SEP : ST_BAD_SCHEME;
                PH_SEP:    err_next = ST_NO_SEP;
                PH_HOST,
                PH_PORT:   err_next = ST_NO_PATH;
                default:   err_next = err_next;
            endcase
        end

        sid = 2'd0;
        if (phase_next != PH_SCHEME)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (cand_next == 4'(1 << i))
                begin
                    sid = 2'(i);
                end
            end
        end

        result.char_class     = cls;
        result.scheme_id      = sid;
        result.port_value     = colon_next ? acc_next : default_port;
        result.port_saturated = sat_next;
        result.status         = err_next;
        result.done_res       = end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCHEME;
            pos_reg   <= 3'd0;
            cand_reg  <= 4'hF;
            acc_reg   <= 16'd0;
            colon_reg <= 1'b0;
            ended_reg <= 1'b0;
            sat_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (step_en)
        begin
            if (end_of_text)
            begin
                phase_reg <= PH_SCHEME;
                pos_reg   <= 3'd0;
                cand_reg  <= 4'hF;
                acc_reg   <= 16'd0;
                colon_reg <= 1'b0;
                ended_reg <= 1'b0;
                sat_reg   <= 1'b0;
                err_reg   <= ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
                acc_reg   <= acc_next;
                colon_reg <= colon_next;
                ended_reg <= ended_next;
                sat_reg   <= sat_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule
